// ===== rtl/core/gradient_projection_profile_defines.svh =====
// ----------------------------------------------------------------------------
// Gradient projection profile: assertion macros
// Shared concurrent-check shorthands, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_PROJECTION_PROFILE_DEFINES_SVH
`define GRADIENT_PROJECTION_PROFILE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define GPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked in the cycle after its antecedent.
`define GPP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Gradient projection profile package
// Payload types, request codes and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package gpp_pkg;

  localparam int unsigned LUMA_W  = 16;
  localparam int unsigned GRAD_W  = 18;
  localparam int unsigned SUM_W   = 27;
  localparam int unsigned RESP_W  = 54;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COORD_W = 12;   // covers the largest legal frame size
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CMD_DEPTH = 4;

  localparam logic [SUM_W-1:0]  SUM_MAX = {SUM_W{1'b1}};
  localparam logic [LUMA_W-1:0] LUMA_WR = 16'd77;
  localparam logic [LUMA_W-1:0] LUMA_WG = 16'd150;
  localparam logic [LUMA_W-1:0] LUMA_WB = 16'd29;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic AXIS_ROW = 1'b0;
  localparam logic AXIS_COL = 1'b1;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [IDX_W-1:0]  column_select;
  } in_item_t;

  typedef struct packed {
    logic              axis;
    logic [IDX_W-1:0]  line_index;
    logic [SUM_W-1:0]  positive_sum;
    logic [SUM_W-1:0]  negative_sum;
    logic [RESP_W-1:0] response;
    logic              out_of_range;
    logic              last_of_run;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic                         is_read;
    logic [LUMA_W-1:0]            luma;
    logic [COORD_W-1:0]           x;
    logic [COORD_W-1:0]           row;
    logic [1:0][COORD_W-1:0]      bank_col;
    logic [1:0]                   bank_upd;
    logic [1:0][GRAD_W-1:0]       bank_grad;
    logic                         rd_bank;
    logic [IDX_W-1:0]             col_sel;
    logic                         oor;
    logic                         first_row;
    logic                         row_ge1;
    logic                         row_eq1;
    logic                         last_row;
    logic                         row_end;
  } cmd_t;

endpackage

// ===== rtl/core/gpp_front.sv =====
// ----------------------------------------------------------------------------
// Gradient projection profile: front end
// Accepts requests, computes luma and horizontal gradients, tracks the raster
// position and classifies each request for the back end.
// ----------------------------------------------------------------------------
module gpp_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WW-1:0]     width_i,
  input  logic [HW-1:0]     height_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gpp_pkg::in_item_t in_data_i,
  output logic              cmd_push_o,
  output gpp_pkg::cmd_t     cmd_o,
  input  logic              cmd_full_i
);
  import gpp_pkg::*;

  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_HEIGHT);
  localparam int unsigned CMPW = (WW > IDX_W) ? WW : IDX_W;

  logic [XW-1:0]            x_q, x_d;
  logic [YW-1:0]            y_q, y_d;
  logic [LUMA_W-1:0]        l1_q, l1_d, l2_q, l2_d;
  logic [LUMA_W-1:0]        luma;
  logic                     accept, is_pix, row_end, last_row, x_ge1, x_eq1;
  logic signed [GRAD_W-1:0] d1, g_inner, g_edge;
  cmd_t                     cmd;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  assign is_pix     = (in_data_i.operation == OP_PIXEL);

  assign luma = LUMA_W'(in_data_i.red) * LUMA_WR + LUMA_W'(in_data_i.green) * LUMA_WG
              + LUMA_W'(in_data_i.blue) * LUMA_WB;

  assign d1      = $signed({2'b00, luma}) - $signed({2'b00, l1_q});
  assign g_edge  = d1 <<< 1;
  assign g_inner = $signed({2'b00, luma}) - $signed({2'b00, l2_q});

  assign row_end  = (WW'(x_q) + WW'(1)) >= width_i;
  assign last_row = (HW'(y_q) + HW'(1)) >= height_i;
  assign x_ge1    = (x_q != '0);
  assign x_eq1    = (x_q == XW'(1));

  always_comb begin
    cmd         = '0;
    cmd.is_read = !is_pix;
    cmd.luma    = luma;
    cmd.x       = COORD_W'(x_q);
    cmd.row     = COORD_W'(y_q);
    cmd.col_sel = in_data_i.column_select;
    if (is_pix) begin
      cmd.first_row = (y_q == '0);
      cmd.row_ge1   = (y_q != '0);
      cmd.row_eq1   = (y_q == YW'(1));
      cmd.last_row  = last_row;
      cmd.row_end   = row_end;
      // column x-1 lands in the bank of opposite parity to x
      cmd.bank_col[~x_q[0]]  = COORD_W'(x_q) - COORD_W'(1);
      cmd.bank_upd[~x_q[0]]  = x_ge1;
      cmd.bank_grad[~x_q[0]] = x_eq1 ? g_edge : g_inner;
      // right edge: column x takes the backward difference
      cmd.bank_col[x_q[0]]   = COORD_W'(x_q);
      cmd.bank_upd[x_q[0]]   = x_ge1 && row_end;
      cmd.bank_grad[x_q[0]]  = g_edge;
    end else begin
      cmd.rd_bank     = in_data_i.column_select[0];
      cmd.bank_col[0] = COORD_W'(in_data_i.column_select);
      cmd.bank_col[1] = COORD_W'(in_data_i.column_select);
      cmd.oor         = CMPW'(in_data_i.column_select) >= CMPW'(width_i);
    end
  end

  assign cmd_push_o = accept;
  assign cmd_o      = cmd;

  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    l1_d = l1_q;
    l2_d = l2_q;
    if (accept && is_pix) begin
      l2_d = l1_q;
      l1_d = luma;
      if (row_end) begin
        x_d = '0;
        y_d = last_row ? '0 : y_q + YW'(1);
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      l1_q <= '0;
      l2_q <= '0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      l1_q <= l1_d;
      l2_q <= l2_d;
    end
  end

endmodule

// ===== rtl/core/gpp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Gradient projection profile: request queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module gpp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gpp_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output gpp_pkg::cmd_t data_o
);
  import gpp_pkg::*;

  localparam int unsigned PW = $clog2(CMD_DEPTH);
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_q [CMD_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

// ===== rtl/core/gpp_back.sv =====
// ----------------------------------------------------------------------------
// Gradient projection profile: back end
// Line buffer and column-sum read-modify-write, row sums, products and the
// output buffer.
// ----------------------------------------------------------------------------
`include "gradient_projection_profile_defines.svh"

module gpp_back #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  gpp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  output gpp_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import gpp_pkg::*;

  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned FW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FCW        = COORD_W + 1;
  localparam int unsigned BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned OF_DEPTH   = 4;
  localparam int unsigned OF_PW      = $clog2(OF_DEPTH);
  localparam int unsigned OF_CW      = $clog2(OF_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] neg;
  } sum_pair_t;

  function automatic sum_pair_t accum(sum_pair_t s, logic signed [GRAD_W-1:0] g);
    sum_pair_t        r;
    logic [GRAD_W-1:0] mag;
    logic [SUM_W:0]   t;
    logic             gpos;
    r    = s;
    gpos = !g[GRAD_W-1] && (g != '0);
    mag  = gpos ? g : -g;
    t    = {1'b0, (gpos ? s.pos : s.neg)} + (SUM_W+1)'(mag);
    if (gpos) begin
      r.pos = t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    end else begin
      r.neg = t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    end
    return r;
  endfunction

  // pipeline control
  logic a_go, b_go, c_go;

  // stage B: request with its memory read data
  logic                b_vld_q;
  cmd_t                b_q;
  logic [2*LUMA_W-1:0] lb_rd_q;
  sum_pair_t           col_rd_q   [2];
  logic [1:0]          byp_q;
  sum_pair_t           byp_data_q [2];
  logic [FW-1:0]       fill_q, fill_d;
  sum_pair_t           pend_q, last_q, pend_acc, last_acc;

  sum_pair_t                old_s [2];
  sum_pair_t                new_s [2];
  logic [LUMA_W-1:0]        cur_l, prv_l;
  logic signed [GRAD_W-1:0] dv_cur, dv_prv, gv, ge;
  logic                     e0, e1;
  logic [1:0]               nres;
  out_item_t                r_s [2];

  // stage C: up to two results waiting for the product
  logic      c_vld_q, c_two_q;
  out_item_t c_q [2];
  out_item_t pc  [2];

  // output buffer
  out_item_t        of_mem_q [OF_DEPTH];
  logic [OF_PW-1:0] of_wr_q, of_rd_q;
  logic [OF_CW-1:0] of_cnt_q;
  logic             of_pop;
  logic [1:0]       of_push;

  // ---------------------------------------------------------------- stage B
  assign cur_l  = lb_rd_q[LUMA_W-1:0];
  assign prv_l  = lb_rd_q[2*LUMA_W-1:LUMA_W];
  assign dv_cur = $signed({2'b00, b_q.luma}) - $signed({2'b00, cur_l});
  assign dv_prv = $signed({2'b00, b_q.luma}) - $signed({2'b00, prv_l});
  assign ge     = dv_cur <<< 1;
  assign gv     = b_q.row_eq1 ? ge : dv_prv;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (byp_q[k]) begin
        old_s[k] = byp_data_q[k];
      end else if (FCW'(b_q.bank_col[k]) < FCW'(fill_q)) begin
        old_s[k] = col_rd_q[k];
      end else begin
        old_s[k] = '0;   // never written since reset
      end
      if (b_q.first_row) begin
        old_s[k] = '0;
      end
      new_s[k] = accum(old_s[k], $signed(b_q.bank_grad[k]));
    end
  end

  assign pend_acc = b_q.row_ge1 ? accum(pend_q, gv) : pend_q;
  assign last_acc = (b_q.row_ge1 && b_q.last_row) ? accum(last_q, ge) : last_q;
  assign e0       = b_q.row_end && b_q.row_ge1;
  assign e1       = b_q.row_end && b_q.last_row;

  always_comb begin
    r_s[0] = '0;
    r_s[1] = '0;
    nres   = 2'd0;
    if (b_q.is_read) begin
      r_s[0].axis         = AXIS_COL;
      r_s[0].line_index   = b_q.col_sel;
      r_s[0].out_of_range = b_q.oor;
      r_s[0].last_of_run  = 1'b1;
      if (!b_q.oor) begin
        r_s[0].positive_sum = old_s[b_q.rd_bank].pos;
        r_s[0].negative_sum = old_s[b_q.rd_bank].neg;
      end
      nres = 2'd1;
    end else if (e0) begin
      r_s[0].axis         = AXIS_ROW;
      r_s[0].line_index   = IDX_W'(b_q.row - COORD_W'(1));
      r_s[0].positive_sum = pend_acc.pos;
      r_s[0].negative_sum = pend_acc.neg;
      r_s[0].last_of_run  = !e1;
      r_s[1].axis         = AXIS_ROW;
      r_s[1].line_index   = IDX_W'(b_q.row);
      r_s[1].positive_sum = last_acc.pos;
      r_s[1].negative_sum = last_acc.neg;
      r_s[1].last_of_run  = 1'b1;
      nres = e1 ? 2'd2 : 2'd1;
    end else if (e1) begin
      r_s[0].axis         = AXIS_ROW;
      r_s[0].line_index   = IDX_W'(b_q.row);
      r_s[0].positive_sum = last_acc.pos;
      r_s[0].negative_sum = last_acc.neg;
      r_s[0].last_of_run  = 1'b1;
      nres = 2'd1;
    end
  end

  // written columns always form a prefix, so one mark tracks them all
  always_comb begin
    fill_d = fill_q;
    for (int k = 0; k < 2; k++) begin
      if (b_q.bank_upd[k] && (FCW'(b_q.bank_col[k]) + FCW'(1) > FCW'(fill_d))) begin
        fill_d = FW'(FCW'(b_q.bank_col[k]) + FCW'(1));
      end
    end
  end

  assign c_go      = c_vld_q && (of_cnt_q <= OF_CW'(OF_DEPTH - 2));
  assign b_go      = b_vld_q && ((nres == 2'd0) || !c_vld_q || c_go);
  assign a_go      = cmd_valid_i && (!b_vld_q || b_go);
  assign cmd_pop_o = a_go;

  // line buffer: each entry holds {row y-2, row y-1}
  logic [2*LUMA_W-1:0] lb_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (b_go && !b_q.is_read) begin
      lb_mem[b_q.x[XW-1:0]] <= {cur_l, b_q.luma};
    end
    if (a_go) begin
      lb_rd_q <= lb_mem[cmd_i.x[XW-1:0]];
    end
  end

  // column sums, split by column parity so a row end can update two columns
  for (genvar k = 0; k < 2; k++) begin : g_bank
    sum_pair_t col_mem [BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (b_go && b_q.bank_upd[k]) begin
        col_mem[BAW'(b_q.bank_col[k] >> 1)] <= new_s[k];
      end
      if (a_go) begin
        col_rd_q[k]   <= col_mem[BAW'(cmd_i.bank_col[k] >> 1)];
        byp_data_q[k] <= new_s[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      byp_q   <= '0;
      fill_q  <= '0;
      pend_q  <= '0;
      last_q  <= '0;
    end else begin
      if (a_go) begin
        b_vld_q <= 1'b1;
        for (int k = 0; k < 2; k++) begin
          byp_q[k] <= b_go && b_q.bank_upd[k] && (b_q.bank_col[k] == cmd_i.bank_col[k]);
        end
      end else if (b_go) begin
        b_vld_q <= 1'b0;
      end
      if (b_go) begin
        fill_q <= fill_d;
        if (!b_q.is_read) begin
          pend_q <= e0 ? '0 : pend_acc;
          last_q <= e1 ? '0 : last_acc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_q <= cmd_i;
    end
  end

  // ---------------------------------------------------------------- stage C
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      c_two_q <= 1'b0;
    end else if (b_go && (nres != 2'd0)) begin
      c_vld_q <= 1'b1;
      c_two_q <= (nres == 2'd2);
    end else if (c_go) begin
      c_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && (nres != 2'd0)) begin
      c_q[0] <= r_s[0];
      c_q[1] <= r_s[1];
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pc[j]          = c_q[j];
      pc[j].response = c_q[j].positive_sum * c_q[j].negative_sum;
    end
  end

  // ---------------------------------------------------------- output buffer
  assign out_valid_o = (of_cnt_q != '0);
  assign out_data_o  = of_mem_q[of_rd_q];
  assign of_pop      = out_valid_o && !out_stall_i;
  assign of_push     = c_go ? (c_two_q ? 2'd2 : 2'd1) : 2'd0;

  always_ff @(posedge clk_i) begin
    if (c_go) begin
      of_mem_q[of_wr_q] <= pc[0];
      if (c_two_q) begin
        of_mem_q[of_wr_q + OF_PW'(1)] <= pc[1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= '0;
      of_rd_q  <= '0;
      of_cnt_q <= '0;
    end else begin
      of_wr_q  <= of_wr_q + OF_PW'(of_push);
      if (of_pop) begin
        of_rd_q <= of_rd_q + OF_PW'(1);
      end
      of_cnt_q <= of_cnt_q + OF_CW'(of_push) - OF_CW'(of_pop);
    end
  end

  // ------------------------------------------------------------- assertions
  `GPP_ASSERT(a_of_bound, of_cnt_q <= OF_CW'(OF_DEPTH), "output buffer overflow")
  `GPP_ASSERT(a_pair_rows, !(c_vld_q && c_two_q) || (c_q[0].axis == AXIS_ROW && c_q[1].axis == AXIS_ROW && !c_q[0].last_of_run && c_q[1].last_of_run), "bad result pair")
  `GPP_ASSERT_NEXT(a_fill_grow, 1'b1, fill_q >= $past(fill_q), "column fill mark shrank")

endmodule

// ===== rtl/core/gradient_projection_profile.sv =====
// ----------------------------------------------------------------------------
// Gradient projection profile: top level
// Throughput: one request per clock unless stalled; each pixel does at most one
// read-modify-write per column bank and line buffer, split over the back end's
// read and update stages.
// Reset: counters, row sums and column fill mark cleared; columns read as zero.
// ----------------------------------------------------------------------------
module gradient_projection_profile #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gpp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gpp_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gpp_pkg::*;

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CLW = (WW > CFG_W) ? WW : CFG_W;
  localparam int unsigned CLH = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0] fw_q, fh_q;
  logic [WW-1:0]    width;
  logic [HW-1:0]    height;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t             cmd_in, cmd_head;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= CFG_W'(640);
      fh_q <= CFG_W'(480);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_q <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(fw_q);
      REG_FRAME_HEIGHT: prdata = 32'(fh_q);
      default:          prdata = '0;
    endcase
  end

  // dimensions in use are clamped to 2..MAX
  assign width  = (fw_q < CFG_W'(2)) ? WW'(2)
                : (CLW'(fw_q) > CLW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_q);
  assign height = (fh_q < CFG_W'(2)) ? HW'(2)
                : (CLH'(fh_q) > CLH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(fh_q);

  gpp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width),
    .height_i   (height),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  gpp_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  gpp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
